// File: sv/prdl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prdl_pkg
// Shared types, codes and modular helpers of the Pollard rho log engine.
// ----------------------------------------------------------------------------
package prdl_pkg;

  localparam int NW = 64;   // number width
  localparam int CW = 32;   // iteration counter width
  localparam int IW = 3;    // config index width

  localparam logic [IW-1:0] CFG_GENERATOR = 3'd0;
  localparam logic [IW-1:0] CFG_MODULUS   = 3'd1;
  localparam logic [IW-1:0] CFG_ORDER     = 3'd2;
  localparam logic [IW-1:0] CFG_LIMIT     = 3'd3;

  localparam logic [1:0] ST_FOUND     = 2'd0;
  localparam logic [1:0] ST_BETA_ZERO = 2'd1;
  localparam logic [1:0] ST_LIMIT     = 2'd2;

  typedef struct packed {
    logic          go;
    logic [NW-1:0] a;
    logic [NW-1:0] b;
    logic [NW-1:0] m;
  } mm_req_t;

  typedef struct packed {
    logic          go;
    logic [NW-1:0] value;
  } m3_req_t;

  // x + y mod m for x, y < m; m of zero wraps
  function automatic logic [NW-1:0] add_mod(input logic [NW-1:0] x,
                                            input logic [NW-1:0] y,
                                            input logic [NW-1:0] m);
    logic [NW:0] s;
    s = {1'b0, x} + {1'b0, y};
    if ((m != '0) && (s >= {1'b0, m})) s = s - {1'b0, m};
    return s[NW-1:0];
  endfunction

  // x - y mod m for x, y < m; m of zero wraps
  function automatic logic [NW-1:0] sub_mod(input logic [NW-1:0] x,
                                            input logic [NW-1:0] y,
                                            input logic [NW-1:0] m);
    logic [NW-1:0] d;
    d = x - y;
    if (x < y) d = d + m;
    return d;
  endfunction

  // 1 mod m
  function automatic logic [NW-1:0] one_mod(input logic [NW-1:0] m);
    return (m == NW'(1)) ? '0 : NW'(1);
  endfunction

endpackage
`default_nettype wire

// File: sv/prdl_mod3.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prdl_mod3
// Bit-serial residue of a value mod 3, one bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module prdl_mod3 (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire prdl_pkg::m3_req_t req_i,
  output logic                   done_o,
  output logic [1:0]             cls_o
);

  logic                    active_q, active_d;
  logic                    done_q, done_d;
  logic [5:0]              cnt_q, cnt_d;
  logic [1:0]              r_q, r_d;
  logic [prdl_pkg::NW-1:0] sh_q, sh_d;
  logic [2:0]              t;

  always_comb begin
    active_d = active_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    r_d      = r_q;
    sh_d     = sh_q;
    t        = {r_q, sh_q[prdl_pkg::NW-1]};
    if (req_i.go) begin
      active_d = 1'b1;
      cnt_d    = '0;
      r_d      = '0;
      sh_d     = req_i.value;
    end else if (active_q) begin
      r_d  = (t >= 3'd3) ? 2'(t - 3'd3) : t[1:0];
      sh_d = sh_q << 1;
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'(prdl_pkg::NW - 1)) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q  <= r_d;
    sh_q <= sh_d;
  end

  assign done_o = done_q;
  assign cls_o  = r_q;

endmodule
`default_nettype wire

// File: sv/prdl_modmul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prdl_modmul
// Bit-serial modular multiplier: double-and-add, a doubling then an add step
// per multiplier bit. A first pass reduces a mod m, a second forms a*b mod m.
// ----------------------------------------------------------------------------
module prdl_modmul (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire prdl_pkg::mm_req_t req_i,
  output logic                   done_o,
  output logic [prdl_pkg::NW-1:0] prod_o
);

  localparam int NW = prdl_pkg::NW;

  logic          active_q, active_d;
  logic          done_q, done_d;
  logic          pass_q, pass_d;
  logic          half_q, half_d;
  logic [5:0]    cnt_q, cnt_d;
  logic [NW-1:0] acc_q, acc_d;
  logic [NW-1:0] addend_q, addend_d;
  logic [NW-1:0] bits_q, bits_d;
  logic [NW-1:0] b_q, b_d;
  logic [NW-1:0] m_q, m_d;
  logic [NW-1:0] acc_add;

  always_comb begin
    active_d = active_q;
    done_d   = 1'b0;
    pass_d   = pass_q;
    half_d   = half_q;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    addend_d = addend_q;
    bits_d   = bits_q;
    b_d      = b_q;
    m_d      = m_q;
    acc_add  = bits_q[NW-1] ? prdl_pkg::add_mod(acc_q, addend_q, m_q) : acc_q;
    if (req_i.go) begin
      active_d = 1'b1;
      pass_d   = 1'b0;
      half_d   = 1'b0;
      cnt_d    = '0;
      acc_d    = '0;
      addend_d = prdl_pkg::one_mod(req_i.m);
      bits_d   = req_i.a;
      b_d      = req_i.b;
      m_d      = req_i.m;
    end else if (active_q) begin
      if (!half_q) begin
        acc_d  = prdl_pkg::add_mod(acc_q, acc_q, m_q);
        half_d = 1'b1;
      end else begin
        acc_d  = acc_add;
        bits_d = bits_q << 1;
        half_d = 1'b0;
        cnt_d  = cnt_q + 6'd1;
        if (cnt_q == 6'(NW - 1)) begin
          if (!pass_q) begin
            // reduced a becomes the addend of the real product
            pass_d   = 1'b1;
            addend_d = acc_add;
            bits_d   = b_q;
            acc_d    = '0;
          end else begin
            active_d = 1'b0;
            done_d   = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      pass_q   <= 1'b0;
      half_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      pass_q   <= pass_d;
      half_q   <= half_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    addend_q <= addend_d;
    bits_q   <= bits_d;
    b_q      <= b_d;
    m_q      <= m_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule
`default_nettype wire

// File: sv/pollard_rho_discrete_log.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pollard_rho_discrete_log
// Pollard rho discrete log search with a serial mod-3 classifier and a shared
// bit-serial modular multiplier.
// ----------------------------------------------------------------------------
// Each walk step runs a mod-3 classification and then a multiply in the
// bit-serial multiplier, three steps and a compare per iteration; a found
// collision then runs a square-and-multiply exponentiation and a final multiply.
// One request at a time: busy is high from acceptance until the result strobe.
// The result is shown for one cycle on done_o; the receiver cannot stall.
// Reset is asynchronous, active low; config returns to its defaults.
// ----------------------------------------------------------------------------
module pollard_rho_discrete_log (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [prdl_pkg::NW-1:0] target_i,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [prdl_pkg::IW-1:0] cfg_index_i,
  input  wire logic [prdl_pkg::NW-1:0] cfg_data_i,
  output logic                         done_o,
  output logic [prdl_pkg::NW-1:0]      log_value_o,
  output logic [1:0]                   status_o
);

  localparam int NW = prdl_pkg::NW;
  localparam int CW = prdl_pkg::CW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLS   = 4'd1;
  localparam logic [3:0] S_CLSW  = 4'd2;
  localparam logic [3:0] S_MULW  = 4'd3;
  localparam logic [3:0] S_CHECK = 4'd4;
  localparam logic [3:0] S_FIN   = 4'd5;
  localparam logic [3:0] S_PSQ   = 4'd6;
  localparam logic [3:0] S_PSQW  = 4'd7;
  localparam logic [3:0] S_PMUL  = 4'd8;
  localparam logic [3:0] S_PMULW = 4'd9;
  localparam logic [3:0] S_LAST  = 4'd10;
  localparam logic [3:0] S_LASTW = 4'd11;

  logic [NW-1:0] gen_q, mod_q, ord_q;
  logic [CW-1:0] lim_q;

  logic [3:0]    state_q, state_d;
  logic [1:0]    step_q, step_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [5:0]    pcnt_q, pcnt_d;
  logic          done_q, done_d;
  logic [NW-1:0] y_q, y_d;
  logic [NW-1:0] av_q, av_d, aa_q, aa_d, ab_q, ab_d;
  logic [NW-1:0] bv_q, bv_d, ba_q, ba_d, bb_q, bb_d;
  logic [NW-1:0] db_q, db_d, da_q, da_d, e_q, e_d, r_q, r_d;
  logic [NW-1:0] log_q, log_d;
  logic [1:0]    st_q, st_d;

  prdl_pkg::mm_req_t mm_req;
  prdl_pkg::m3_req_t m3_req;
  logic              mm_done, m3_done;
  logic [NW-1:0]     mm_prod;
  logic [1:0]        m3_cls;

  logic          use_b;
  logic [NW-1:0] cur_v, cur_a, cur_b, one_ord, db_c;

  prdl_mod3 u_mod3 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (m3_req),
    .done_o (m3_done),
    .cls_o  (m3_cls)
  );

  prdl_modmul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mm_req),
    .done_o (mm_done),
    .prod_o (mm_prod)
  );

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q <= '0;
      mod_q <= '0;
      ord_q <= '0;
      lim_q <= '1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        prdl_pkg::CFG_GENERATOR: gen_q <= cfg_data_i;
        prdl_pkg::CFG_MODULUS:   mod_q <= cfg_data_i;
        prdl_pkg::CFG_ORDER:     ord_q <= cfg_data_i;
        prdl_pkg::CFG_LIMIT:     lim_q <= cfg_data_i[CW-1:0];
        default: ;
      endcase
    end
  end

  assign use_b   = (step_q != 2'd0);
  assign cur_v   = use_b ? bv_q : av_q;
  assign cur_a   = use_b ? ba_q : aa_q;
  assign cur_b   = use_b ? bb_q : ab_q;
  assign one_ord = prdl_pkg::one_mod(ord_q);
  assign db_c    = prdl_pkg::sub_mod(ab_q, bb_q, ord_q);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cnt_d   = cnt_q;
    pcnt_d  = pcnt_q;
    done_d  = 1'b0;
    y_d     = y_q;
    av_d = av_q; aa_d = aa_q; ab_d = ab_q;
    bv_d = bv_q; ba_d = ba_q; bb_d = bb_q;
    db_d = db_q; da_d = da_q; e_d = e_q; r_d = r_q;
    log_d = log_q;
    st_d  = st_q;
    m3_req.go    = 1'b0;
    m3_req.value = cur_v;
    mm_req.go    = 1'b0;
    mm_req.a     = cur_v;
    mm_req.b     = y_q;
    mm_req.m     = mod_q;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          y_d  = target_i;
          av_d = NW'(1); aa_d = '0; ab_d = '0;
          bv_d = NW'(1); ba_d = '0; bb_d = '0;
          cnt_d   = '0;
          step_d  = '0;
          state_d = S_CLS;
        end
      end
      S_CLS: begin
        m3_req.go = 1'b1;
        state_d   = S_CLSW;
      end
      S_CLSW: begin
        if (m3_done) begin
          mm_req.go = 1'b1;
          case (m3_cls)
            2'd1: begin
              mm_req.b = y_q;
              if (use_b) bb_d = prdl_pkg::add_mod(cur_b, one_ord, ord_q);
              else       ab_d = prdl_pkg::add_mod(cur_b, one_ord, ord_q);
            end
            2'd0: begin
              mm_req.b = cur_v;
              if (use_b) begin
                ba_d = prdl_pkg::add_mod(cur_a, cur_a, ord_q);
                bb_d = prdl_pkg::add_mod(cur_b, cur_b, ord_q);
              end else begin
                aa_d = prdl_pkg::add_mod(cur_a, cur_a, ord_q);
                ab_d = prdl_pkg::add_mod(cur_b, cur_b, ord_q);
              end
            end
            default: begin
              mm_req.b = gen_q;
              if (use_b) ba_d = prdl_pkg::add_mod(cur_a, one_ord, ord_q);
              else       aa_d = prdl_pkg::add_mod(cur_a, one_ord, ord_q);
            end
          endcase
          state_d = S_MULW;
        end
      end
      S_MULW: begin
        if (mm_done) begin
          if (use_b) bv_d = mm_prod;
          else       av_d = mm_prod;
          if (step_q == 2'd2) begin
            step_d  = '0;
            cnt_d   = cnt_q + CW'(1);
            state_d = S_CHECK;
          end else begin
            step_d  = step_q + 2'd1;
            state_d = S_CLS;
          end
        end
      end
      S_CHECK: begin
        if (av_q == bv_q) begin
          state_d = S_FIN;
        end else if (cnt_q >= lim_q) begin
          log_d   = '0;
          st_d    = prdl_pkg::ST_LIMIT;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_CLS;
        end
      end
      S_FIN: begin
        if (db_c == '0) begin
          log_d   = '0;
          st_d    = prdl_pkg::ST_BETA_ZERO;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          db_d    = db_c;
          da_d    = prdl_pkg::sub_mod(ba_q, aa_q, ord_q);
          e_d     = ord_q - NW'(2);
          r_d     = one_ord;
          pcnt_d  = '0;
          state_d = S_PSQ;
        end
      end
      S_PSQ: begin
        mm_req.go = 1'b1;
        mm_req.a  = r_q;
        mm_req.b  = r_q;
        mm_req.m  = ord_q;
        state_d   = S_PSQW;
      end
      S_PMUL: begin
        mm_req.go = 1'b1;
        mm_req.a  = r_q;
        mm_req.b  = db_q;
        mm_req.m  = ord_q;
        state_d   = S_PMULW;
      end
      S_PSQW, S_PMULW: begin
        if (mm_done) begin
          r_d = mm_prod;
          if ((state_q == S_PSQW) && e_q[NW-1]) begin
            state_d = S_PMUL;
          end else begin
            e_d    = e_q << 1;
            pcnt_d = pcnt_q + 6'd1;
            state_d = (pcnt_q == 6'(NW - 1)) ? S_LAST : S_PSQ;
          end
        end
      end
      S_LAST: begin
        mm_req.go = 1'b1;
        mm_req.a  = da_q;
        mm_req.b  = r_q;
        mm_req.m  = ord_q;
        state_d   = S_LASTW;
      end
      S_LASTW: begin
        if (mm_done) begin
          log_d   = mm_prod;
          st_d    = prdl_pkg::ST_FOUND;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      cnt_q   <= '0;
      pcnt_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      cnt_q   <= cnt_d;
      pcnt_q  <= pcnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    y_q <= y_d;
    av_q <= av_d; aa_q <= aa_d; ab_q <= ab_d;
    bv_q <= bv_d; ba_q <= ba_d; bb_q <= bb_d;
    db_q <= db_d; da_q <= da_d; e_q <= e_d; r_q <= r_d;
    log_q <= log_d;
    st_q  <= st_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign log_value_o = log_q;
  assign status_o    = st_q;

endmodule
`default_nettype wire

// File: sv/prdl_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prdl_checker
// Port-level checks of the request/result sequencing, bound to the top level.
// ----------------------------------------------------------------------------
module prdl_checker (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    start,
  input wire logic                    busy,
  input wire logic                    done_o,
  input wire logic [prdl_pkg::NW-1:0] log_value_o,
  input wire logic [1:0]              status_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accepted request did not raise busy");

  a_fall_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o) else $error("busy dropped without a result");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy ##1 !done_o) else $error("result strobe while busy or too long");

  a_status_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != prdl_pkg::ST_FOUND) |-> (log_value_o == '0))
    else $error("nonzero log value on failed search");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == prdl_pkg::ST_FOUND) || (status_o == prdl_pkg::ST_BETA_ZERO)
               || (status_o == prdl_pkg::ST_LIMIT)) else $error("bad status code");

endmodule

bind pollard_rho_discrete_log prdl_checker u_prdl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .done_o      (done_o),
  .log_value_o (log_value_o),
  .status_o    (status_o)
);
`default_nettype wire
